// ===== rtl/irn_pkg.sv =====
// Shared types and constants of the nearest-neighbour image rotation block.
package irn_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int DIM_W     = 9;
    localparam int COORD_W   = 8;
    localparam int PIX_W     = 24;
    localparam int FACTOR_W  = 16;
    localparam int CFG_W     = 16;
    localparam int REG_IDX_W = 2;

    localparam int FRAC_BITS  = 14;
    localparam int HALF_SHIFT = FRAC_BITS + 1;
    localparam int DX_W       = DIM_W + 2;
    localparam int PROD_W     = FACTOR_W + DX_W;
    localparam int ACC_W      = 32;

    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

    localparam logic [DIM_W-1:0]    RST_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]    RST_HEIGHT = 9'd256;
    localparam logic [FACTOR_W-1:0] RST_COS    = 16'd16384;
    localparam logic [FACTOR_W-1:0] RST_SIN    = 16'd0;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_COS    = 2'd2,
        REG_SIN    = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_BLACK = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [FACTOR_W-1:0] cos_f;
        logic [FACTOR_W-1:0] sin_f;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [PIX_W-1:0]  pixel;
    } cmd_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             in_image;
    } res_t;

endpackage

// ===== rtl/irn_fifo.sv =====
// Small register queue used between the front, the back and the result port.
module irn_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == LVL_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign level   = count_reg;
    assign rdata   = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + LVL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/irn_front.sv =====
// Front part: accepts items, classifies them and maps read coordinates to source addresses.
module irn_front #(
    parameter int MAX_WIDTH  = irn_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = irn_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       push,
    output logic                                       full,
    input  logic                                       func,
    input  logic [irn_pkg::COORD_W-1:0]                col,
    input  logic [irn_pkg::COORD_W-1:0]                row,
    input  logic [irn_pkg::PIX_W-1:0]                  pixel_in,
    input  irn_pkg::cfg_t                              cfg,
    output logic                                       q_push,
    output irn_pkg::cmd_t                              q_cmd,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    q_addr,
    input  logic                                       q_full
);
    import irn_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(MAX_WIDTH);

    logic [DIM_W-1:0]           w_eff;
    logic [DIM_W-1:0]           h_eff;
    logic signed [FACTOR_W-1:0] cos_f;
    logic signed [FACTOR_W-1:0] sin_f;
    logic                       adv;
    logic                       take;
    logic                       in_range;

    logic                       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    cmd_kind_t                  s1_kind_reg, s2_kind_reg, s3_kind_reg;
    logic [ADDR_W-1:0]          s1_addr_reg, s2_addr_reg, s3_addr_reg;
    logic [PIX_W-1:0]           s1_pix_reg, s2_pix_reg, s3_pix_reg;
    logic signed [DX_W-1:0]     s1_dx_reg, s1_dy_reg;
    logic signed [PROD_W-1:0]   s2_cx_reg, s2_sy_reg, s2_sx_reg, s2_cy_reg;
    logic signed [ACC_W-1:0]    s3_nx_reg, s3_ny_reg;

    logic                       s1_valid_next;
    cmd_kind_t                  s1_kind_next;
    logic [ADDR_W-1:0]          s1_addr_next;
    logic signed [DX_W-1:0]     s1_dx_next, s1_dy_next;
    logic signed [ACC_W-1:0]    s3_nx_next, s3_ny_next;

    logic signed [ACC_W-1:0]    sx;
    logic signed [ACC_W-1:0]    sy;
    logic                       src_in_image;
    logic [ADDR_W-1:0]          rd_addr;

    assign w_eff = (32'(cfg.width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg.width;
    assign h_eff = (32'(cfg.height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : cfg.height;
    assign cos_f = $signed(cfg.cos_f);
    assign sin_f = $signed(cfg.sin_f);

    // Hold the whole pipe while the last stage waits on the command queue
    assign adv    = !(s3_valid_reg && q_full);
    assign full   = !adv;
    assign take   = push && adv;
    assign q_push = s3_valid_reg && !q_full;

    // Stage 1: classify and centre the coordinate in half-pixel units
    always_comb
    begin
        in_range      = ({1'b0, col} < w_eff) && ({1'b0, row} < h_eff);
        s1_valid_next = take && (in_range || func == FUNC_READ);
        if (func == FUNC_WRITE)
        begin
            s1_kind_next = CMD_WRITE;
        end
        else if (in_range)
        begin
            s1_kind_next = CMD_READ;
        end
        else
        begin
            s1_kind_next = CMD_BLACK;
        end
        s1_addr_next = ADDR_W'(ADDR_W'(row) * STRIDE) + ADDR_W'(col);
        s1_dx_next   = $signed({2'b00, col, 1'b0}) - $signed({2'b00, w_eff - DIM_W'(1)});
        s1_dy_next   = $signed({2'b00, row, 1'b0}) - $signed({2'b00, h_eff - DIM_W'(1)});
    end

    // Stage 3: rotated position in Q.15, centre offset and the half added
    always_comb
    begin
        s3_nx_next = ACC_W'(s2_cx_reg) - ACC_W'(s2_sy_reg)
                   + $signed(ACC_W'({w_eff, FRAC_BITS'(0)}));
        s3_ny_next = ACC_W'(s2_sx_reg) + ACC_W'(s2_cy_reg)
                   + $signed(ACC_W'({h_eff, FRAC_BITS'(0)}));
    end

    // Truncate toward zero: bias negative values before the shift
    always_comb
    begin
        sx = (s3_nx_reg + $signed(ACC_W'({HALF_SHIFT{s3_nx_reg[ACC_W-1]}}))) >>> HALF_SHIFT;
        sy = (s3_ny_reg + $signed(ACC_W'({HALF_SHIFT{s3_ny_reg[ACC_W-1]}}))) >>> HALF_SHIFT;
        src_in_image = !sx[ACC_W-1] && !sy[ACC_W-1]
                    && ($unsigned(sx) < ACC_W'(w_eff))
                    && ($unsigned(sy) < ACC_W'(h_eff));
        rd_addr = ADDR_W'(ADDR_W'(sy) * STRIDE) + ADDR_W'(sx);

        q_cmd.pixel = s3_pix_reg;
        q_cmd.kind  = s3_kind_reg;
        q_addr      = s3_addr_reg;
        if (s3_kind_reg == CMD_READ)
        begin
            q_addr = rd_addr;
            if (!src_in_image)
            begin
                q_cmd.kind = CMD_BLACK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg <= s1_kind_next;
            s1_addr_reg <= s1_addr_next;
            s1_pix_reg  <= pixel_in;
            s1_dx_reg   <= s1_dx_next;
            s1_dy_reg   <= s1_dy_next;

            s2_kind_reg <= s1_kind_reg;
            s2_addr_reg <= s1_addr_reg;
            s2_pix_reg  <= s1_pix_reg;
            s2_cx_reg   <= PROD_W'(cos_f * s1_dx_reg);
            s2_sy_reg   <= PROD_W'(sin_f * s1_dy_reg);
            s2_sx_reg   <= PROD_W'(sin_f * s1_dx_reg);
            s2_cy_reg   <= PROD_W'(cos_f * s1_dy_reg);

            s3_kind_reg <= s2_kind_reg;
            s3_addr_reg <= s2_addr_reg;
            s3_pix_reg  <= s2_pix_reg;
            s3_nx_reg   <= s3_nx_next;
            s3_ny_reg   <= s3_ny_next;
        end
    end

endmodule

// ===== rtl/irn_back.sv =====
// Back part: frame store, pixel writes and reads, results toward the output queue.
module irn_back #(
    parameter int MAX_WIDTH  = irn_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = irn_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cmd_empty,
    input  irn_pkg::cmd_t                              cmd,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    cmd_addr,
    output logic                                       cmd_pop,
    input  logic [irn_pkg::OUT_LVL_W-1:0]              out_level,
    output logic                                       out_push,
    output irn_pkg::res_t                              out_res
);
    import irn_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;

    logic [PIX_W-1:0] frame_mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;
    logic             rd_valid_reg, rd_valid_next;
    logic             rd_black_reg, rd_black_next;
    logic             room;
    logic             is_write;
    logic             wr_en;
    logic             rd_en;

    // Count the read in flight so the output queue can never overflow
    assign room     = (({1'b0, out_level} + (OUT_LVL_W + 1)'(rd_valid_reg))
                       < (OUT_LVL_W + 1)'(OUT_DEPTH));
    assign is_write = (cmd.kind == CMD_WRITE);
    assign cmd_pop  = !cmd_empty && (is_write || room);
    assign wr_en    = cmd_pop && is_write;
    assign rd_en    = cmd_pop && (cmd.kind == CMD_READ);

    assign rd_valid_next = cmd_pop && !is_write;
    assign rd_black_next = (cmd.kind != CMD_READ);

    assign out_push         = rd_valid_reg;
    assign out_res.pixel    = rd_black_reg ? '0 : rd_data_reg;
    assign out_res.in_image = !rd_black_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[cmd_addr] <= cmd.pixel;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[cmd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            rd_black_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_valid_next;
            rd_black_reg <= rd_black_next;
        end
    end

endmodule

// ===== rtl/image_rotate_nearest_unit.sv =====
// Top level of the nearest-neighbour image rotation block.
//
//  channel   direction  handshake        payload
//  items     in         push / full      func, col, row, pixel_in
//  results   out        pop / empty      pixel_out, inside_res
//  config    in         cfg_we           cfg_index, cfg_data
//
// One item is taken a cycle while the queues have room; the single-port frame
// memory allows one write or one read a cycle. A read's result passes the three
// mapping stages, the command queue, the memory read and the result queue on its
// way to the result ports. Reset empties the queues and loads the default size
// and factors; the store is not cleared. full rises when the command queue backs
// up; the back holds reads while the result queue lacks room.
module image_rotate_nearest_unit #(
    parameter int MAX_WIDTH  = irn_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = irn_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             func,
    input  logic [irn_pkg::COORD_W-1:0]      col,
    input  logic [irn_pkg::COORD_W-1:0]      row,
    input  logic [irn_pkg::PIX_W-1:0]        pixel_in,
    output logic                             empty,
    input  logic                             pop,
    output logic [irn_pkg::PIX_W-1:0]        pixel_out,
    output logic                             inside_res,
    input  logic                             cfg_we,
    input  logic [irn_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [irn_pkg::CFG_W-1:0]        cfg_data
);
    import irn_pkg::*;

    localparam int ADDR_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int CMD_BITS = $bits(cmd_t) + ADDR_W;
    localparam int RES_BITS = $bits(res_t);

    cfg_t              cfg_reg, cfg_next;

    logic              fq_push;
    cmd_t              fq_cmd;
    logic [ADDR_W-1:0] fq_addr;
    logic              cq_full;
    logic              cq_empty;
    logic              cq_pop;
    logic [CMD_BITS-1:0] cq_rdata;
    cmd_t              cq_cmd;
    logic [ADDR_W-1:0] cq_addr;

    logic              oq_push;
    res_t              oq_wres;
    logic [RES_BITS-1:0] oq_rdata;
    res_t              oq_rres;
    logic [OUT_LVL_W-1:0] oq_level;
    logic              oq_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_WIDTH:  cfg_next.width  = cfg_data[DIM_W-1:0];
                REG_HEIGHT: cfg_next.height = cfg_data[DIM_W-1:0];
                REG_COS:    cfg_next.cos_f  = cfg_data[FACTOR_W-1:0];
                REG_SIN:    cfg_next.sin_f  = cfg_data[FACTOR_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= RST_WIDTH;
            cfg_reg.height <= RST_HEIGHT;
            cfg_reg.cos_f  <= RST_COS;
            cfg_reg.sin_f  <= RST_SIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    irn_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .func     (func),
        .col      (col),
        .row      (row),
        .pixel_in (pixel_in),
        .cfg      (cfg_reg),
        .q_push   (fq_push),
        .q_cmd    (fq_cmd),
        .q_addr   (fq_addr),
        .q_full   (cq_full)
    );

    irn_fifo #(
        .WIDTH (CMD_BITS),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata ({fq_addr, fq_cmd}),
        .full  (cq_full),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .empty (cq_empty),
        .level ()
    );

    assign cq_addr = cq_rdata[CMD_BITS-1 -: ADDR_W];
    assign cq_cmd  = cmd_t'(cq_rdata[$bits(cmd_t)-1:0]);

    irn_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cq_empty),
        .cmd       (cq_cmd),
        .cmd_addr  (cq_addr),
        .cmd_pop   (cq_pop),
        .out_level (oq_level),
        .out_push  (oq_push),
        .out_res   (oq_wres)
    );

    irn_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push && !oq_full),
        .wdata (oq_wres),
        .full  (oq_full),
        .pop   (pop),
        .rdata (oq_rdata),
        .empty (empty),
        .level (oq_level)
    );

    assign oq_rres    = res_t'(oq_rdata);
    assign pixel_out  = oq_rres.pixel;
    assign inside_res = oq_rres.in_image;

endmodule
